/* src/stu_pkg.sv */
package stu_pkg;

    localparam int SpaceDim = 3;
    localparam int CntW     = $clog2(2 * SpaceDim + 1);

    // 0.067 as Q0.32, and 100 in Q16.16 for the percent figure.
    localparam logic [31:0] Frac0p067 = 32'd287762809;
    localparam logic [31:0] DevScale  = 32'd6553600;

    typedef enum logic [2:0] {
        REG_SMOOTH  = 3'd0,
        REG_REST    = 3'd1,
        REG_VISC    = 3'd2,
        REG_SURF    = 3'd3,
        REG_SOUND   = 3'd4,
        REG_CFL     = 3'd5,
        REG_MINSTEP = 3'd6,
        REG_MAXSTEP = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_UPD,
        S_GO,
        S_WAIT,
        S_HOLD
    } state_t;

    typedef enum logic [4:0] {
        ST_SMUL,
        ST_SDIV,
        ST_SSQRT,
        ST_ASQRT,
        ST_FDIV,
        ST_FSQRT,
        ST_VSQRT,
        ST_VDIV,
        ST_HH,
        ST_HR0,
        ST_HR1,
        ST_VISC,
        ST_SURF,
        ST_RDIV,
        ST_RSQRT,
        ST_CDIV,
        ST_SAFE,
        ST_DT,
        ST_PMUL,
        ST_PDIV
    } step_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_ALU
    } op_t;

    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
    } div_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] x;
    } sqrt_req_t;

    function automatic op_t step_op(input step_t s);
        op_t o;
        case (s)
            ST_SDIV, ST_FDIV, ST_VDIV, ST_VISC, ST_RDIV, ST_CDIV, ST_PDIV: o = OP_DIV;
            ST_SSQRT, ST_ASQRT, ST_FSQRT, ST_VSQRT, ST_RSQRT:              o = OP_SQRT;
            ST_SAFE:                                                       o = OP_ALU;
            default:                                                       o = OP_MUL;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] raw);
        return raw[31] ? (~raw + 32'd1) : raw;
    endfunction

endpackage

/* src/stu_div.sv */
module stu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  stu_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quo
);
    import stu_pkg::*;

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] num_reg, num_next;
    logic [63:0]  den_reg, den_next;
    logic [63:0]  r_reg, r_next;
    logic [63:0]  q_reg, q_next;
    logic         sat_reg, sat_next;
    logic [63:0]  r_sh;
    logic         take;

    // Restoring division, one quotient bit per cycle over the 128-bit dividend.
    always_comb begin
        r_sh      = {r_reg[62:0], num_reg[127]};
        take      = r_reg[63] | (r_sh >= den_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            num_next  = req.num;
            den_next  = req.den;
            r_next    = 64'd0;
            q_next    = 64'd0;
            sat_next  = 1'b0;
        end else if (busy_reg) begin
            num_next = {num_reg[126:0], 1'b0};
            sat_next = sat_reg | q_reg[63];
            r_next   = take ? (r_sh - den_reg) : r_sh;
            q_next   = {q_reg[62:0], take};
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd127) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quo  = sat_reg ? 64'hFFFF_FFFF_FFFF_FFFF : q_reg;

endmodule

/* src/stu_sqrt.sv */
module stu_sqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  stu_pkg::sqrt_req_t req,
    output logic               done,
    output logic [31:0]        root
);
    import stu_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [35:0] rem_sh, trial;
    logic        take;

    // Digit-by-digit square root, one result bit per cycle.
    always_comb begin
        rem_sh    = {rem_reg, x_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            x_next    = req.x;
            rem_next  = 34'd0;
            root_next = 32'd0;
        end else if (busy_reg) begin
            x_next    = {x_reg[61:0], 2'b00};
            rem_next  = take ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_next = {root_reg[30:0], take};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* src/sph_stable_timestep_reduction.sv */
// A particle with zero curvature passes through the squaring steps, the update state and the
// idle state; nonzero curvature adds a multiply, the shared bit-serial divider and the square
// root. The last particle then goes on to the six constraints and the outputs: six divisions,
// four square roots and seven multiply or compare steps. One particle is in work at a time;
// a finished result waits until the output register frees.
// Reset (synchronous, active low) restores register defaults and sets the peaks to one.
module sph_stable_timestep_reduction (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x, accel_y, accel_z, vel_x, vel_y, vel_z, density_rate, density(31),
    // curvature, frame_remaining, one pad bit
    input  logic [319:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // time_step, safe_step, density_dev_pct(31), one pad bit
    output logic [95:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import stu_pkg::*;

    logic [30:0] h_reg, rest_reg, visc_reg, surf_reg, sound_reg;
    logic [17:0] cfl_reg;
    logic [31:0] min_reg, max_reg;

    logic [31:0] accel_reg [3];
    logic [31:0] vel_reg [3];
    logic [31:0] rate_in_reg, curv_reg, frame_reg;
    logic [30:0] dens_reg;
    logic        last_reg;

    logic [63:0] peak_acc_reg, peak_acc_next;
    logic [63:0] peak_spd_reg, peak_spd_next;
    logic [31:0] peak_rate_reg, peak_rate_next;
    logic [31:0] peak_dev_reg, peak_dev_next;
    logic [31:0] least_surf_reg, least_surf_next;

    state_t          state_reg, state_next;
    step_t           step_reg, step_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    logic [63:0] acc_reg, acc_next, spd_reg, spd_next;
    logic [63:0] prod_reg, t_reg, t_next, least_reg, least_next;
    logic [95:0] wide_reg, wide_next;
    logic [31:0] safe_reg, safe_next, time_reg, time_next;
    logic [31:0] mul_a, mul_b;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [95:0] m_tdata_reg, m_tdata_next;

    div_req_t    div_req;
    sqrt_req_t   sqrt_req;
    logic        div_done, sqrt_done, op_done, out_free;
    logic [63:0] div_quo;
    logic [31:0] sqrt_root;

    logic [CntW-1:0] acc_idx, vel_idx;
    logic [31:0]     comp;
    logic [30:0]     dev;
    logic [31:0]     rate_mag;
    logic [63:0]     cand;
    logic            use_cand;
    logic            emit;
    logic [65:0]     s3;
    logic [33:0]     dt34;
    logic [31:0]     dt_cl;
    logic [32:0]     frame_sum;
    logic [30:0]     rr;

    stu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quo     (div_quo)
    );

    stu_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // Configuration port.
    assign pready = 1'b1;

    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_SMOOTH:  prdata = {1'b0, h_reg};
            REG_REST:    prdata = {1'b0, rest_reg};
            REG_VISC:    prdata = {1'b0, visc_reg};
            REG_SURF:    prdata = {1'b0, surf_reg};
            REG_SOUND:   prdata = {1'b0, sound_reg};
            REG_CFL:     prdata = {14'd0, cfl_reg};
            REG_MINSTEP: prdata = min_reg;
            REG_MAXSTEP: prdata = max_reg;
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg     <= 31'd65536;
            rest_reg  <= 31'd65536000;
            visc_reg  <= 31'd65536;
            surf_reg  <= 31'd65536;
            sound_reg <= 31'd65536;
            cfl_reg   <= 18'd65536;
            min_reg   <= 32'd1;
            max_reg   <= 32'hFFFF_FFFF;
        end else if (psel && penable && pwrite) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_SMOOTH:  h_reg     <= pwdata[30:0];
                REG_REST:    rest_reg  <= pwdata[30:0];
                REG_VISC:    visc_reg  <= pwdata[30:0];
                REG_SURF:    surf_reg  <= pwdata[30:0];
                REG_SOUND:   sound_reg <= pwdata[30:0];
                REG_CFL:     cfl_reg   <= pwdata[17:0];
                REG_MINSTEP: min_reg   <= pwdata;
                REG_MAXSTEP: max_reg   <= pwdata;
                default:     ;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign rr       = (rest_reg == 31'd0) ? 31'd1 : rest_reg;

    always_comb begin
        case (step_op(step_reg))
            OP_DIV:  op_done = div_done;
            OP_SQRT: op_done = sqrt_done;
            default: op_done = 1'b1;
        endcase
    end

    // Next state and step.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SQ;
                    cnt_next   = '0;
                end
            end
            S_SQ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(2 * SpaceDim)) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (curv_reg != 32'd0) begin
                    state_next = S_GO;
                    step_next  = ST_SMUL;
                end else if (last_reg) begin
                    state_next = S_GO;
                    step_next  = ST_ASQRT;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_GO: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (op_done) begin
                    state_next = S_GO;
                    case (step_reg)
                        ST_SMUL:  step_next = ST_SDIV;
                        ST_SDIV:  step_next = ST_SSQRT;
                        ST_SSQRT: begin
                            if (last_reg) begin
                                step_next = ST_ASQRT;
                            end else begin
                                state_next = S_IDLE;
                            end
                        end
                        ST_ASQRT: step_next = ST_FDIV;
                        ST_FDIV:  step_next = ST_FSQRT;
                        ST_FSQRT: step_next = ST_VSQRT;
                        ST_VSQRT: step_next = ST_VDIV;
                        ST_VDIV:  step_next = ST_HH;
                        ST_HH:    step_next = ST_HR0;
                        ST_HR0:   step_next = ST_HR1;
                        ST_HR1:   step_next = ST_VISC;
                        ST_VISC:  step_next = ST_SURF;
                        ST_SURF:  step_next = ST_RDIV;
                        ST_RDIV:  step_next = ST_RSQRT;
                        ST_RSQRT: step_next = ST_CDIV;
                        ST_CDIV:  step_next = ST_SAFE;
                        ST_SAFE:  step_next = ST_DT;
                        ST_DT:    step_next = ST_PMUL;
                        ST_PMUL:  step_next = ST_PDIV;
                        ST_PDIV: begin
                            // Hold the finished result until the output register frees.
                            if (out_free) begin
                                state_next = S_IDLE;
                            end else begin
                                state_next = S_HOLD;
                            end
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        acc_idx  = cnt_reg - 1'b1;
        vel_idx  = cnt_reg - CntW'(SpaceDim);
        comp     = (cnt_reg < CntW'(SpaceDim)) ? mag32(accel_reg[cnt_reg[1:0]])
                                              : mag32(vel_reg[vel_idx[1:0]]);
        dev      = (dens_reg >= rest_reg) ? (dens_reg - rest_reg) : (rest_reg - dens_reg);
        rate_mag = mag32(rate_in_reg);
        s3       = {2'b00, least_reg} + {1'b0, least_reg, 1'b0};
        dt34     = prod_reg[49:16];
        if (dt34 < {2'b00, min_reg}) begin
            dt_cl = min_reg;
        end else if (dt34 > {2'b00, max_reg}) begin
            dt_cl = max_reg;
        end else begin
            dt_cl = dt34[31:0];
        end
        frame_sum = {1'b0, frame_reg} + {1'b0, min_reg};
        // The quotient stays in the divider until the next start, so a held result
        // can still be read from it.
        emit = out_free && (step_reg == ST_PDIV)
               && (((state_reg == S_WAIT) && op_done) || (state_reg == S_HOLD));

        mul_a = 32'd0;
        mul_b = 32'd0;
        div_req.start  = 1'b0;
        div_req.num    = 128'd0;
        div_req.den    = 64'd1;
        sqrt_req.start = 1'b0;
        sqrt_req.x     = 64'd0;
        cand     = 64'hFFFF_FFFF_FFFF_FFFF;
        use_cand = 1'b0;

        acc_next        = acc_reg;
        spd_next        = spd_reg;
        peak_acc_next   = peak_acc_reg;
        peak_spd_next   = peak_spd_reg;
        peak_rate_next  = peak_rate_reg;
        peak_dev_next   = peak_dev_reg;
        least_surf_next = least_surf_reg;
        t_next          = t_reg;
        wide_next       = wide_reg;
        least_next      = least_reg;
        safe_next       = safe_reg;
        time_next       = time_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        case (step_reg)
            ST_SMUL: begin mul_a = {1'b0, dens_reg}; mul_b = {1'b0, surf_reg}; end
            ST_HH:   begin mul_a = {1'b0, h_reg};    mul_b = {1'b0, h_reg}; end
            ST_HR0:  begin mul_a = t_reg[31:0];      mul_b = {1'b0, rest_reg}; end
            ST_HR1:  begin mul_a = t_reg[63:32];     mul_b = {1'b0, rest_reg}; end
            ST_SURF: begin mul_a = least_surf_reg;   mul_b = Frac0p067; end
            ST_DT:   begin mul_a = safe_reg;         mul_b = {14'd0, cfl_reg}; end
            ST_PMUL: begin mul_a = peak_dev_reg;     mul_b = DevScale; end
            default: ;
        endcase

        case (step_reg)
            ST_SDIV: begin
                div_req.num = {48'd0, prod_reg, 16'd0};
                div_req.den = {32'd0, mag32(curv_reg)};
            end
            ST_FDIV: begin
                div_req.num = {45'd0, h_reg, 52'd0};
                div_req.den = (t_reg == 64'd0) ? 64'd1 : t_reg;
            end
            ST_VDIV: begin
                div_req.num = {68'd0, h_reg, 29'd0};
                div_req.den = (t_reg == 64'd0) ? 64'd1 : t_reg;
            end
            ST_VISC: begin
                div_req.num = {32'd0, wide_reg};
                div_req.den = {26'd0, (visc_reg == 31'd0) ? 31'd1 : visc_reg, 7'd0};
            end
            ST_RDIV: begin
                div_req.num = {43'd0, h_reg, 54'd0};
                div_req.den = {32'd0, (peak_rate_reg == 32'd0) ? 32'd1 : peak_rate_reg};
            end
            ST_CDIV: begin
                div_req.num = {68'd0, {2'b00, h_reg} + {1'b0, h_reg, 1'b0}, 27'd0};
                div_req.den = {33'd0, (sound_reg == 31'd0) ? 31'd1 : sound_reg};
            end
            ST_PDIV: begin
                div_req.num = {64'd0, prod_reg};
                div_req.den = {33'd0, rr};
            end
            default: ;
        endcase

        case (step_reg)
            ST_SSQRT, ST_FSQRT, ST_RSQRT: sqrt_req.x = div_quo;
            ST_ASQRT:                     sqrt_req.x = peak_acc_reg;
            ST_VSQRT:                     sqrt_req.x = peak_spd_reg;
            default:                      ;
        endcase

        if (state_reg == S_GO) begin
            div_req.start  = (step_op(step_reg) == OP_DIV);
            sqrt_req.start = (step_op(step_reg) == OP_SQRT);
        end

        case (state_reg)
            S_IDLE: begin
                acc_next = 64'd0;
                spd_next = 64'd0;
            end
            S_SQ: begin
                mul_a = comp;
                mul_b = comp;
                if (cnt_reg != '0) begin
                    if (acc_idx < CntW'(SpaceDim)) begin
                        acc_next = acc_reg + prod_reg;
                    end else begin
                        spd_next = spd_reg + prod_reg;
                    end
                end
            end
            S_UPD: begin
                if (acc_reg > peak_acc_reg)          peak_acc_next  = acc_reg;
                if (spd_reg > peak_spd_reg)          peak_spd_next  = spd_reg;
                if (rate_mag > peak_rate_reg)        peak_rate_next = rate_mag;
                if ({1'b0, dev} > peak_dev_reg)      peak_dev_next  = {1'b0, dev};
            end
            S_WAIT: begin
                if (op_done) begin
                    case (step_reg)
                        ST_SSQRT: begin
                            if (sqrt_root < least_surf_reg) least_surf_next = sqrt_root;
                        end
                        ST_ASQRT, ST_VSQRT: t_next = {32'd0, sqrt_root};
                        ST_FSQRT: least_next = {32'd0, sqrt_root};
                        ST_VDIV, ST_VISC, ST_CDIV: begin
                            cand = div_quo;
                            use_cand = 1'b1;
                        end
                        ST_RSQRT: begin
                            cand = {32'd0, sqrt_root};
                            use_cand = 1'b1;
                        end
                        ST_SURF: begin
                            cand = {20'd0, prod_reg[63:20]};
                            use_cand = 1'b1;
                        end
                        ST_HH:  t_next = prod_reg;
                        ST_HR0: wide_next = {32'd0, prod_reg};
                        ST_HR1: wide_next = wide_reg + {prod_reg, 32'd0};
                        ST_SAFE: begin
                            safe_next = (s3[65:34] != 32'd0) ? 32'hFFFF_FFFF : s3[33:2];
                        end
                        ST_DT: begin
                            if (dt_cl > frame_reg) begin
                                time_next = frame_sum[32] ? 32'hFFFF_FFFF : frame_sum[31:0];
                            end else begin
                                time_next = dt_cl;
                            end
                        end
                        default: ;
                    endcase
                    if (use_cand && (cand < least_reg)) least_next = cand;
                end
            end
            default: ;
        endcase

        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0,
                             (div_quo[63:31] != 33'd0) ? 31'h7FFF_FFFF : div_quo[30:0],
                             safe_reg, time_reg};
            peak_acc_next   = 64'd1;
            peak_spd_next   = 64'd1;
            peak_rate_next  = 32'd1;
            peak_dev_next   = 32'd1;
            least_surf_next = 32'hFFFF_FFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            step_reg       <= ST_SMUL;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            peak_acc_reg   <= 64'd1;
            peak_spd_reg   <= 64'd1;
            peak_rate_reg  <= 32'd1;
            peak_dev_reg   <= 32'd1;
            least_surf_reg <= 32'hFFFF_FFFF;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            cnt_reg        <= cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
            peak_acc_reg   <= peak_acc_next;
            peak_spd_reg   <= peak_spd_next;
            peak_rate_reg  <= peak_rate_next;
            peak_dev_reg   <= peak_dev_next;
            least_surf_reg <= least_surf_next;
        end
        if (s_tvalid && s_tready) begin
            accel_reg[0] <= s_tdata[31:0];
            accel_reg[1] <= s_tdata[63:32];
            accel_reg[2] <= s_tdata[95:64];
            vel_reg[0]   <= s_tdata[127:96];
            vel_reg[1]   <= s_tdata[159:128];
            vel_reg[2]   <= s_tdata[191:160];
            rate_in_reg  <= s_tdata[223:192];
            dens_reg     <= s_tdata[254:224];
            curv_reg     <= s_tdata[286:255];
            frame_reg    <= s_tdata[318:287];
            last_reg     <= s_tlast;
        end
        prod_reg    <= {32'd0, mul_a} * {32'd0, mul_b};
        acc_reg     <= acc_next;
        spd_reg     <= spd_next;
        t_reg       <= t_next;
        wide_reg    <= wide_next;
        least_reg   <= least_next;
        safe_reg    <= safe_next;
        time_reg    <= time_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_WAIT) && (step_op(step_reg) == OP_DIV))
        else $error("divider finished outside its wait step");

    a_sqrt_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == S_WAIT) && (step_op(step_reg) == OP_SQRT))
        else $error("square root finished outside its wait step");

    a_out_from_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_WAIT || state_reg == S_HOLD)
                                && $past(step_reg == ST_PDIV))
        else $error("result raised outside the final step");

endmodule
